/* rtl/mvd_pkg.sv */
// Shared types, opcode patterns and helpers for the MOV instruction decoder.
package mvd_pkg;

  localparam logic [5:0] OPC_RM_REG  = 6'b100010;
  localparam logic [3:0] OPC_IMM_REG = 4'b1011;
  localparam logic [6:0] OPC_IMM_RM  = 7'b1100011;
  localparam logic [6:0] OPC_MEM_ACC = 7'b1010000;
  localparam logic [6:0] OPC_ACC_MEM = 7'b1010001;

  localparam logic [2:0] RM_DIRECT = 3'b110;
  localparam logic [1:0] MOD_REG   = 2'b11;
  localparam logic [1:0] MOD_DISP8  = 2'b01;
  localparam logic [1:0] MOD_DISP16 = 2'b10;
  localparam logic [1:0] MOD_MEM    = 2'b00;
  localparam logic [2:0] REG_ACC    = 3'b000;

  localparam logic [2:0] FORM_RM_REG  = 3'd0;
  localparam logic [2:0] FORM_IMM_REG = 3'd1;
  localparam logic [2:0] FORM_IMM_RM  = 3'd2;
  localparam logic [2:0] FORM_MEM_ACC = 3'd3;
  localparam logic [2:0] FORM_ACC_MEM = 3'd4;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [2:0]  form;
    logic        to_reg;
    logic        wide;
    logic [1:0]  mode;
    logic [2:0]  reg_field;
    logic [2:0]  rm_field;
    logic [15:0] displacement;
    logic [15:0] immediate;
  } rec_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic [1:0] disp_size(input logic [1:0] md, input logic [2:0] rm);
    logic [1:0] n;
    n = 2'd0;
    if (md == MOD_DISP8) n = 2'd1;
    else if (md == MOD_DISP16) n = 2'd2;
    else if (md == MOD_MEM && rm == RM_DIRECT) n = 2'd2;
    return n;
  endfunction

endpackage

/* rtl/mvd_front.sv */
// Front end: takes code bytes, recognizes opcodes and assembles decoded records.
module mvd_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic [7:0]      in_data,
  output logic            in_ready,
  input  mvd_pkg::q_stat_t q_stat,
  output logic            push,
  output mvd_pkg::rec_t   push_rec
);

  localparam logic [2:0] PH_IDLE    = 3'd0;
  localparam logic [2:0] PH_MODRM   = 3'd1;
  localparam logic [2:0] PH_DISP_LO = 3'd2;
  localparam logic [2:0] PH_DISP_HI = 3'd3;
  localparam logic [2:0] PH_IMM_LO  = 3'd4;
  localparam logic [2:0] PH_IMM_HI  = 3'd5;

  logic [2:0]    phase, phase_next;
  logic [2:0]    left, left_next;
  mvd_pkg::rec_t rec, rec_next;
  logic [1:0]    dn;
  logic          done;

  assign in_ready = !q_stat.full;

  always_comb begin
    phase_next = phase;
    left_next  = left;
    rec_next   = rec;
    done       = 1'b0;
    dn         = mvd_pkg::disp_size(in_data[7:6], in_data[2:0]);
    if (in_valid && in_ready) begin
      if (phase == PH_IDLE) begin
        if (in_data[7:2] == mvd_pkg::OPC_RM_REG) begin
          rec_next        = '0;
          rec_next.form   = mvd_pkg::FORM_RM_REG;
          rec_next.to_reg = in_data[1];
          rec_next.wide   = in_data[0];
          phase_next      = PH_MODRM;
          left_next       = 3'd1;
        end else if (in_data[7:4] == mvd_pkg::OPC_IMM_REG) begin
          rec_next           = '0;
          rec_next.form      = mvd_pkg::FORM_IMM_REG;
          rec_next.to_reg    = 1'b1;
          rec_next.wide      = in_data[3];
          rec_next.mode      = mvd_pkg::MOD_REG;
          rec_next.reg_field = in_data[2:0];
          phase_next         = PH_IMM_LO;
          left_next          = 3'd1 + {2'b00, in_data[3]};
        end else if (in_data[7:1] == mvd_pkg::OPC_IMM_RM) begin
          rec_next      = '0;
          rec_next.form = mvd_pkg::FORM_IMM_RM;
          rec_next.wide = in_data[0];
          phase_next    = PH_MODRM;
          left_next     = 3'd1;
        end else if (in_data[7:1] == mvd_pkg::OPC_MEM_ACC ||
                     in_data[7:1] == mvd_pkg::OPC_ACC_MEM) begin
          rec_next          = '0;
          rec_next.form     = (in_data[7:1] == mvd_pkg::OPC_MEM_ACC) ?
                              mvd_pkg::FORM_MEM_ACC : mvd_pkg::FORM_ACC_MEM;
          rec_next.to_reg   = (in_data[7:1] == mvd_pkg::OPC_MEM_ACC);
          rec_next.wide     = in_data[0];
          rec_next.mode     = mvd_pkg::MOD_MEM;
          rec_next.reg_field = mvd_pkg::REG_ACC;
          rec_next.rm_field = mvd_pkg::RM_DIRECT;
          phase_next        = PH_DISP_LO;
          left_next         = 3'd2;
        end
      end else begin
        left_next = left - 3'd1;
        unique case (phase)
          PH_MODRM: begin
            rec_next.mode      = in_data[7:6];
            rec_next.reg_field = in_data[5:3];
            rec_next.rm_field  = in_data[2:0];
            left_next = {1'b0, dn} + ((rec.form == mvd_pkg::FORM_IMM_RM) ?
                                      (3'd1 + {2'b00, rec.wide}) : 3'd0);
            phase_next = (dn != 2'd0) ? PH_DISP_LO : PH_IMM_LO;
          end
          PH_DISP_LO: begin
            if (rec.mode == mvd_pkg::MOD_DISP8) begin
              rec_next.displacement = {{8{in_data[7]}}, in_data};
              phase_next = PH_IMM_LO;
            end else begin
              rec_next.displacement = {8'h00, in_data};
              phase_next = PH_DISP_HI;
            end
          end
          PH_DISP_HI: begin
            rec_next.displacement[15:8] = in_data;
            phase_next = PH_IMM_LO;
          end
          PH_IMM_LO: begin
            rec_next.immediate = {8'h00, in_data};
            phase_next = PH_IMM_HI;
          end
          default: begin
            rec_next.immediate[15:8] = in_data;
            phase_next = PH_IDLE;
          end
        endcase
        if (left_next == 3'd0) begin
          phase_next = PH_IDLE;
          done       = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      left  <= 3'd0;
    end else begin
      phase <= phase_next;
      left  <= left_next;
    end
    rec <= rec_next;
  end

  assign push     = done;
  assign push_rec = rec_next;

endmodule

/* rtl/mvd_fifo.sv */
// Short register queue of decoded records between the front and back ends.
module mvd_fifo (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  mvd_pkg::rec_t    push_rec,
  input  logic             pop,
  output mvd_pkg::rec_t    pop_rec,
  output mvd_pkg::q_stat_t stat
);

  mvd_pkg::rec_t                 entries [mvd_pkg::QDEPTH];
  logic [mvd_pkg::QPTR_W-1:0]    wr_ptr, rd_ptr;
  logic [mvd_pkg::QCNT_W-1:0]    count;
  logic                          do_push, do_pop;

  assign stat.full  = (count == mvd_pkg::QCNT_W'(mvd_pkg::QDEPTH));
  assign stat.empty = (count == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign pop_rec    = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == mvd_pkg::QPTR_W'(mvd_pkg::QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == mvd_pkg::QPTR_W'(mvd_pkg::QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
    if (do_push) begin
      entries[wr_ptr] <= push_rec;
    end
  end

endmodule

/* rtl/mvd_back.sv */
// Back end: computes the instruction length and holds the result for the output side.
module mvd_back (
  input  logic             clk,
  input  logic             rst,
  input  mvd_pkg::rec_t    q_rec,
  input  mvd_pkg::q_stat_t q_stat,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_ready,
  output mvd_pkg::rec_t    out_rec,
  output logic [2:0]       out_len
);

  logic [2:0] len_calc;
  logic [2:0] dlen;

  assign pop  = !q_stat.empty && (!out_valid || out_ready);
  assign dlen = {1'b0, mvd_pkg::disp_size(q_rec.mode, q_rec.rm_field)};

  always_comb begin
    case (q_rec.form)
      mvd_pkg::FORM_RM_REG:  len_calc = 3'd2 + dlen;
      mvd_pkg::FORM_IMM_REG: len_calc = 3'd2 + {2'b00, q_rec.wide};
      mvd_pkg::FORM_IMM_RM:  len_calc = 3'd3 + dlen + {2'b00, q_rec.wide};
      default:               len_calc = 3'd3;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (pop) begin
      out_rec <= q_rec;
      out_len <= len_calc;
    end
  end

endmodule

/* rtl/x86_mov_instruction_decoder.sv */
// Top level of the 16-bit x86 MOV instruction decoder.
// The decoder takes one code byte per cycle and emits one record per recognized MOV
// instruction; unknown opcode bytes are dropped. The record of an instruction is written
// into a two-entry queue at the edge that takes its last byte and moves from the queue into
// the output register when that register is empty or its result is being taken. The
// queue parts the front end from the output, so the input keeps taking bytes while a
// result waits to be taken; the input stalls only when that queue is full.
module x86_mov_instruction_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // byte_in
  output logic        m_tvalid,
  input  logic        m_tready,
  // to_reg, wide, mode[1:0], reg_field[2:0], rm_field[2:0], displacement[15:0],
  // immediate[15:0], length[2:0], zero fill
  output logic [47:0] m_tdata,
  output logic [2:0]  m_tuser    // form
);

  mvd_pkg::q_stat_t q_stat;
  mvd_pkg::rec_t    push_rec, q_rec, out_rec;
  logic             push, pop;
  logic [2:0]       out_len;

  mvd_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_data  (s_tdata),
    .in_ready (s_tready),
    .q_stat   (q_stat),
    .push     (push),
    .push_rec (push_rec)
  );

  mvd_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_rec (push_rec),
    .pop      (pop),
    .pop_rec  (q_rec),
    .stat     (q_stat)
  );

  mvd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_rec     (q_rec),
    .q_stat    (q_stat),
    .pop       (pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_rec   (out_rec),
    .out_len   (out_len)
  );

  assign m_tuser = out_rec.form;
  assign m_tdata = {3'b000, out_len, out_rec.immediate, out_rec.displacement,
                    out_rec.rm_field, out_rec.reg_field, out_rec.mode,
                    out_rec.wide, out_rec.to_reg};

  a_len_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (out_len != 3'd0 && out_len != 3'd7))
    else $error("Decoded length out of range.");

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !q_stat.full)
    else $error("Record pushed into a full queue.");

  a_imm_reg: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && out_rec.form == mvd_pkg::FORM_IMM_REG) |->
      (out_rec.mode == mvd_pkg::MOD_REG && out_rec.to_reg && out_rec.displacement == 16'h0))
    else $error("Immediate-to-register record has memory fields.");

  a_acc: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (out_rec.form == mvd_pkg::FORM_MEM_ACC ||
                  out_rec.form == mvd_pkg::FORM_ACC_MEM)) |->
      (out_rec.rm_field == mvd_pkg::RM_DIRECT && out_rec.mode == mvd_pkg::MOD_MEM &&
       out_len == 3'd3))
    else $error("Accumulator record has wrong addressing fields.");

endmodule
